[sv/assert_macros.svh]
// Assertion macros shared by the vector norm, distance and dot product RTL.
// Included by the modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/vnd_pkg.sv]
// Types and fixed widths for the vector norm, distance and dot product block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vnd_pkg;

  localparam int IN_W      = 16;  // width of an element field
  localparam int ELEM_BITS = 16;  // elements are sign extended from these bits
  localparam int OPND_W    = 17;  // multiplier operand, wide enough for a - b
  localparam int PROD_W    = 2 * OPND_W;
  localparam int SQ_A_W    = 41;
  localparam int SQ_B_W    = 41;
  localparam int SQ_DIFF_W = 43;
  localparam int DOT_W     = 42;
  localparam int ACC_W     = 43;  // width of the shared accumulate adder
  localparam int NORM_W    = 21;
  localparam int DIST_W    = 22;
  localparam int ROOT_W    = 22;
  localparam int RAD_W     = 2 * ROOT_W;

  typedef enum logic [1:0] {
    OP_SQ_A    = 2'd0,
    OP_SQ_B    = 2'd1,
    OP_SQ_DIFF = 2'd2,
    OP_DOT     = 2'd3
  } mac_op_t;

  typedef struct packed {
    logic    issue;  // start a multiply for op this cycle
    mac_op_t op;
    logic    clear;  // zero all accumulators
  } mac_ctrl_t;

  function automatic logic signed [OPND_W-1:0] sext_elem(input logic [IN_W-1:0] x);
    return OPND_W'($signed(x[ELEM_BITS-1:0]));
  endfunction

endpackage

[sv/vnd_mac.sv]
// Shared multiplier and accumulate adder holding the four running sums.
// Depends on vnd_pkg; driven by the sequencer in vector_norm_distance_dot.
`timescale 1ns / 1ps

module vnd_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [vnd_pkg::OPND_W-1:0]     a,
  input  logic signed [vnd_pkg::OPND_W-1:0]     b,
  input  vnd_pkg::mac_ctrl_t                    ctrl,
  output logic        [vnd_pkg::SQ_A_W-1:0]     sum_sq_a,
  output logic        [vnd_pkg::SQ_B_W-1:0]     sum_sq_b,
  output logic        [vnd_pkg::SQ_DIFF_W-1:0]  sum_sq_diff,
  output logic        [vnd_pkg::DOT_W-1:0]      dot_acc
);
  import vnd_pkg::*;

  logic signed [OPND_W-1:0] diff;
  logic signed [OPND_W-1:0] opnd_x;
  logic signed [OPND_W-1:0] opnd_y;
  logic signed [PROD_W-1:0] prod;
  mac_op_t                  prod_op;
  logic                     prod_valid;
  logic        [ACC_W-1:0]  acc_sel;
  logic        [ACC_W-1:0]  prod_ext;
  logic        [ACC_W-1:0]  acc_sum;

  // Operands stay within 16 bits, so the difference fits the operand width.
  assign diff = a - b;

  always_comb begin
    unique case (ctrl.op)
      OP_SQ_A: begin
        opnd_x = a;
        opnd_y = a;
      end
      OP_SQ_B: begin
        opnd_x = b;
        opnd_y = b;
      end
      OP_SQ_DIFF: begin
        opnd_x = diff;
        opnd_y = diff;
      end
      OP_DOT: begin
        opnd_x = a;
        opnd_y = b;
      end
      default: begin
        opnd_x = a;
        opnd_y = b;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.issue;
    end
    prod    <= PROD_W'(opnd_x) * PROD_W'(opnd_y);
    prod_op <= ctrl.op;
  end

  always_comb begin
    unique case (prod_op)
      OP_SQ_A:    acc_sel = ACC_W'(sum_sq_a);
      OP_SQ_B:    acc_sel = ACC_W'(sum_sq_b);
      OP_SQ_DIFF: acc_sel = ACC_W'(sum_sq_diff);
      OP_DOT:     acc_sel = ACC_W'(dot_acc);
      default:    acc_sel = ACC_W'(dot_acc);
    endcase
  end

  // Each sum wraps at its own width, so the upper adder bits are simply dropped.
  assign prod_ext = unsigned'(ACC_W'(prod));
  assign acc_sum  = acc_sel + prod_ext;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sum_sq_a    <= '0;
      sum_sq_b    <= '0;
      sum_sq_diff <= '0;
      dot_acc     <= '0;
    end else if (prod_valid) begin
      unique case (prod_op)
        OP_SQ_A:    sum_sq_a    <= acc_sum[SQ_A_W-1:0];
        OP_SQ_B:    sum_sq_b    <= acc_sum[SQ_B_W-1:0];
        OP_SQ_DIFF: sum_sq_diff <= acc_sum[SQ_DIFF_W-1:0];
        OP_DOT:     dot_acc     <= acc_sum[DOT_W-1:0];
        default:    dot_acc     <= acc_sum[DOT_W-1:0];
      endcase
    end
  end

endmodule

[sv/vnd_sqrt.sv]
// Iterative floor square root, two radicand bits per cycle.
// Depends on vnd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vnd_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [vnd_pkg::RAD_W-1:0]     radicand,
  output logic                          done,
  output logic [vnd_pkg::ROOT_W-1:0]    root
);
  import vnd_pkg::*;

  localparam int REM_W  = ROOT_W + 4;
  localparam int ITER_W = $clog2(ROOT_W);

  logic              busy;
  logic [ITER_W-1:0] iter;
  logic [RAD_W-1:0]  rad_sh;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // Bring down the next two radicand bits and try appending a one to the root.
  assign rem_sh = {rem[REM_W-3:0], rad_sh[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root, 2'b01});
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (iter == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (iter == '0)) begin
        busy <= 1'b0;
      end
    end
    if (start) begin
      rad_sh <= radicand;
      rem    <= '0;
      root   <= '0;
      iter   <= ITER_W'(ROOT_W - 1);
    end else if (busy) begin
      rad_sh <= {rad_sh[RAD_W-3:0], 2'b00};
      rem    <= fits ? (rem_sh - trial) : rem_sh;
      root   <= {root[ROOT_W-2:0], fits};
      iter   <= iter - ITER_W'(1);
    end
  end

  `ASSERT_CLK(a_no_restart, clk, rst, start |-> !busy, "square root restarted while busy")
  `ASSERT_CLK(a_done_idle, clk, rst, done |-> !busy, "square root done while still iterating")

endmodule

[sv/vector_norm_distance_dot.sv]
// Top level: sequencer, element counters and result registers.
// Depends on vnd_pkg, vnd_mac, vnd_sqrt and assert_macros.svh.
//
// Usage:
//   An element pair is one transaction, accepted at a rising edge where start
//   is high and busy is low. has_a and has_b say which side is present; last
//   closes the vectors. Elements beyond MAX_LEN on a side are dropped and
//   reported through overflowed.
//   Each transaction runs four products through one shared multiplier and one
//   shared accumulate adder: busy stays high through the four products and the
//   drain that follows, so a new pair is taken only once the previous one has drained.
//   On a last pair one iterative square root unit then runs three times, and
//   done is high for exactly one cycle, once the distance root is registered,
//   with norm_a, norm_b, distance, dot, lengths_match and overflowed valid in
//   that cycle only. The receiver cannot stall; the result must be taken in
//   that cycle. All sums, counts and the overflow flag clear as the result
//   leaves.
//   A synchronous reset clears the sums, counts and sequencer; the block is
//   ready in the cycle after reset falls.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vector_norm_distance_dot #(
  parameter int MAX_LEN = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic        [vnd_pkg::IN_W-1:0]      elem_a,
  input  logic        [vnd_pkg::IN_W-1:0]      elem_b,
  input  logic                                 has_a,
  input  logic                                 has_b,
  input  logic                                 last,
  output logic                                 done,
  output logic        [vnd_pkg::NORM_W-1:0]    norm_a,
  output logic        [vnd_pkg::NORM_W-1:0]    norm_b,
  output logic        [vnd_pkg::DIST_W-1:0]    distance,
  output logic signed [vnd_pkg::DOT_W-1:0]     dot,
  output logic                                 lengths_match,
  output logic                                 overflowed
);
  import vnd_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_MAC       = 6'b000010,
    S_DRAIN     = 6'b000100,
    S_ROOT_GO   = 6'b001000,
    S_ROOT_WAIT = 6'b010000,
    S_DONE      = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    ROOT_A    = 2'd0,
    ROOT_B    = 2'd1,
    ROOT_DIFF = 2'd2
  } root_sel_t;

  state_t                   state;
  state_t                   state_next;
  mac_op_t                  op_cnt;
  root_sel_t                root_sel;
  logic                     last_r;
  logic signed [OPND_W-1:0] a_r;
  logic signed [OPND_W-1:0] b_r;
  logic [CNT_W-1:0]         count_a;
  logic [CNT_W-1:0]         count_b;
  logic                     overflow_flag;
  logic                     accept;
  logic                     take_a;
  logic                     take_b;
  mac_ctrl_t                mac_ctrl;
  logic [SQ_A_W-1:0]        sum_sq_a;
  logic [SQ_B_W-1:0]        sum_sq_b;
  logic [SQ_DIFF_W-1:0]     sum_sq_diff;
  logic [DOT_W-1:0]         dot_acc;
  logic                     sq_start;
  logic                     sq_done;
  logic [RAD_W-1:0]         radicand;
  logic [ROOT_W-1:0]        root;
  logic [NORM_W-1:0]        norm_a_r;
  logic [NORM_W-1:0]        norm_b_r;
  logic [DIST_W-1:0]        dist_r;

  assign accept = start && !busy;
  assign take_a = has_a && (count_a < MAX_CNT);
  assign take_b = has_b && (count_b < MAX_CNT);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (start) state_next = S_MAC;
      S_MAC:       if (op_cnt == OP_DOT) state_next = S_DRAIN;
      S_DRAIN:     state_next = last_r ? S_ROOT_GO : S_IDLE;
      S_ROOT_GO:   state_next = S_ROOT_WAIT;
      S_ROOT_WAIT: begin
        if (sq_done) state_next = (root_sel == ROOT_DIFF) ? S_DONE : S_ROOT_GO;
      end
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      op_cnt        <= OP_SQ_A;
      root_sel      <= ROOT_A;
      last_r        <= 1'b0;
      count_a       <= '0;
      count_b       <= '0;
      overflow_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        last_r  <= last;
        op_cnt  <= OP_SQ_A;
        count_a <= count_a + CNT_W'(take_a);
        count_b <= count_b + CNT_W'(take_b);
        if ((has_a && !take_a) || (has_b && !take_b)) begin
          overflow_flag <= 1'b1;
        end
      end else if (state == S_MAC) begin
        op_cnt <= mac_op_t'(op_cnt + 2'd1);
      end
      if (state == S_DRAIN) begin
        root_sel <= ROOT_A;
      end else if ((state == S_ROOT_WAIT) && sq_done && (root_sel != ROOT_DIFF)) begin
        root_sel <= root_sel_t'(root_sel + 2'd1);
      end
      if (state == S_DONE) begin
        count_a       <= '0;
        count_b       <= '0;
        overflow_flag <= 1'b0;
      end
    end
  end

  // A dropped or absent element enters every sum as zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_r <= take_a ? sext_elem(elem_a) : '0;
      b_r <= take_b ? sext_elem(elem_b) : '0;
    end
    if ((state == S_ROOT_WAIT) && sq_done) begin
      unique case (root_sel)
        ROOT_A:    norm_a_r <= root[NORM_W-1:0];
        ROOT_B:    norm_b_r <= root[NORM_W-1:0];
        ROOT_DIFF: dist_r   <= root[DIST_W-1:0];
        default:   dist_r   <= root[DIST_W-1:0];
      endcase
    end
  end

  assign mac_ctrl.issue = (state == S_MAC);
  assign mac_ctrl.op    = op_cnt;
  assign mac_ctrl.clear = (state == S_DONE);

  vnd_mac u_mac (
    .clk         (clk),
    .rst         (rst),
    .a           (a_r),
    .b           (b_r),
    .ctrl        (mac_ctrl),
    .sum_sq_a    (sum_sq_a),
    .sum_sq_b    (sum_sq_b),
    .sum_sq_diff (sum_sq_diff),
    .dot_acc     (dot_acc)
  );

  always_comb begin
    unique case (root_sel)
      ROOT_A:    radicand = RAD_W'(sum_sq_a);
      ROOT_B:    radicand = RAD_W'(sum_sq_b);
      ROOT_DIFF: radicand = RAD_W'(sum_sq_diff);
      default:   radicand = RAD_W'(sum_sq_diff);
    endcase
  end

  assign sq_start = (state == S_ROOT_GO);

  vnd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (radicand),
    .done     (sq_done),
    .root     (root)
  );

  assign busy          = (state != S_IDLE);
  assign done          = (state == S_DONE);
  assign norm_a        = norm_a_r;
  assign norm_b        = norm_b_r;
  assign distance      = dist_r;
  assign dot           = $signed(dot_acc);
  assign lengths_match = (count_a == count_b);
  assign overflowed    = overflow_flag;

  `ASSERT_CLK(a_accept_busy, clk, rst, (start && !busy) |=> busy, "accepted transaction not busy")
  `ASSERT_CLK(a_done_pulse, clk, rst, done |=> (!done && !busy), "result strobe held or block stuck")
  `ASSERT_CLK(a_root_in_wait, clk, rst, sq_done |-> (state == S_ROOT_WAIT), "root finished out of sequence")

endmodule
